[rtl/rcmc_pkg.sv]
// Shared constants, register indexes and helper functions for the min-cut unit.
`default_nettype none
package rcmc_pkg;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_EDGES    = 4096;

  localparam int VC_W   = 9;
  localparam int TC_W   = 16;
  localparam int SEED_W = 32;
  localparam int CUT_W  = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CUT_W-1:0] CUT_ALL_ONES = {CUT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 2'd0,
    CFG_TRIAL_COUNT  = 2'd1,
    CFG_RNG_SEED     = 2'd2
  } cfg_idx_t;

  // One xorshift32 step: shifts 13 left, 17 right, 5 left.
  function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] x);
    logic [SEED_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

endpackage
`default_nettype wire

[rtl/rcmc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rcmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                                     clk,
  input  wire                                     we,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                         wdata,
  input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

[rtl/random_contraction_min_cut_unit.sv]
// Top level: randomized edge-contraction minimum-cut search over a stored graph.
//
//  channel | ports                          | word contents (lowest bit first)
//  --------+--------------------------------+------------------------------------
//  in      | in_tvalid/in_tready/in_tdata   | edge_head[8:0], edge_tail[17:9], 0s
//          | in_tlast                       | last_edge: final edge, starts trials
//  out     | out_tvalid/out_tready/out_tdata| min_cut[12:0], stalled[13], 0s
//  cfg     | cfg_we/cfg_index/cfg_wdata     | 0 vertex_count, 1 trial_count, 2 rng_seed
//
// Edge words load at one per cycle while the sequencer is idle. A word with
// tlast launches the trials; input stays stalled until the result is registered.
// Per trial: a mark/label init sweep, then per draw an xorshift step and a
// bit-serial 32-step modulo, a mark check, and the label check and loop test when
// the drawn edge is fresh, a relabel sweep per merge, and a final cut count; the
// steps run in sequence since each memory has a single read port. Reset (rst_n
// low, synchronous) clears control state only; the
// edge memory needs no init because only entries below the load count are read.
// A pending result holds on out_* until taken; new edges load meanwhile.
`default_nettype none
module random_contraction_min_cut_unit #(
  parameter int MAX_VERTICES = rcmc_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = rcmc_pkg::DEF_MAX_EDGES
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [23:0]                      in_tdata,   // edge_head[8:0], edge_tail[17:9]
  input  wire                              in_tlast,   // last_edge
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [15:0]                      out_tdata,  // min_cut[12:0], stalled[13]
  input  wire                              cfg_we,
  input  wire  [rcmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rcmc_pkg::SEED_W-1:0]      cfg_wdata
);

  import rcmc_pkg::*;

  // Widths derived from the storage sizes.
  localparam int CW   = $clog2(MAX_EDGES + 1);        // edge counts
  localparam int AW   = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int VW   = MAX_VERTICES > 1 ? $clog2(MAX_VERTICES) : 1;
  localparam int NVW  = $clog2(MAX_VERTICES + 1);     // vertex counts
  localparam int SW   = CW > NVW ? CW : NVW;          // init sweep counter
  localparam int CMPW = NVW > VC_W ? NVW : VC_W;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_TINIT = 16'h0002,
    S_CHECK = 16'h0004,
    S_DRAW  = 16'h0008,
    S_MOD   = 16'h0010,
    S_MREAD = 16'h0020,
    S_MCHK  = 16'h0040,
    S_LCHK  = 16'h0080,
    S_RRD   = 16'h0100,
    S_RWR   = 16'h0200,
    S_CRD   = 16'h0400,
    S_CLB   = 16'h0800,
    S_CCMP  = 16'h1000,
    S_TEND  = 16'h2000,
    S_FIN   = 16'h4000,
    S_SPARE = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic [VC_W-1:0]   vcount_r;
  logic [TC_W-1:0]   tcount_r;
  logic [SEED_W-1:0] rng_r, rng_nxt;

  logic [CW-1:0]     load_cnt_r, load_cnt_nxt;
  logic [CUT_W-1:0]  best_r, best_nxt;
  logic [TC_W-1:0]   trial_r, trial_nxt;
  logic              stall_r, stall_nxt;
  logic [SW-1:0]     sweep_r, sweep_nxt;
  logic [CW-1:0]     left_r, left_nxt;
  logic [NVW-1:0]    merges_r, merges_nxt;
  logic [NVW-1:0]    vidx_r, vidx_nxt;
  logic [CW-1:0]     eidx_r, eidx_nxt;
  logic [CUT_W-1:0]  cut_r, cut_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [SEED_W-1:0] word_r, word_nxt;
  logic [4:0]        bit_r, bit_nxt;
  logic [VW-1:0]     ga_r, ga_nxt, gb_r, gb_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CUT_W-1:0]  out_cut_r, out_cut_nxt;
  logic              out_stall_r, out_stall_nxt;

  // Memory ports.
  logic              edge_we, mark_we, lab_we;
  logic [AW-1:0]     edge_waddr, edge_raddr, mark_waddr, mark_raddr;
  logic [2*VW-1:0]   edge_wdata, edge_rdata;
  logic              mark_wdata, mark_rdata;
  logic [VW-1:0]     lab_waddr, lab_wdata, laba_raddr, labb_raddr, laba_rdata, labb_rdata;

  // Effective vertex count and input edge check.
  logic [CMPW-1:0]   vc_ext, nv_full, head_ext, tail_ext;
  logic [NVW-1:0]    nv;
  logic [8:0]        in_head, in_tail;
  logic              edge_ok, accept;
  logic [CW:0]       rem_sh;
  logic [TC_W:0]     trials;

  assign in_head  = in_tdata[8:0];
  assign in_tail  = in_tdata[17:9];
  assign vc_ext   = CMPW'(vcount_r);
  assign nv_full  = (vc_ext < CMPW'(MAX_VERTICES)) ? vc_ext : CMPW'(MAX_VERTICES);
  assign nv       = NVW'(nv_full);
  assign head_ext = CMPW'(in_head);
  assign tail_ext = CMPW'(in_tail);
  assign edge_ok  = (in_head != 9'd0) && (head_ext <= nv_full) &&
                    (in_tail != 9'd0) && (tail_ext <= nv_full) &&
                    (load_cnt_r < CW'(MAX_EDGES));
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign rem_sh    = {rem_r, word_r[SEED_W-1]};
  assign trials    = (tcount_r == '0) ? (TC_W+1)'(1) : {1'b0, tcount_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_stall_r, out_cut_r};

  // Edge store: head label in the low half, tail label in the high half.
  rcmc_ram #(.WIDTH(2*VW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  rcmc_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_mark_ram (
    .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
    .raddr(mark_raddr), .rdata(mark_rdata)
  );

  // Two copies of the group labels so head and tail read in the same cycle.
  rcmc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_laba_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(laba_raddr), .rdata(laba_rdata)
  );

  rcmc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_labb_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(labb_raddr), .rdata(labb_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    rng_nxt       = rng_r;
    load_cnt_nxt  = load_cnt_r;
    best_nxt      = best_r;
    trial_nxt     = trial_r;
    stall_nxt     = stall_r;
    sweep_nxt     = sweep_r;
    left_nxt      = left_r;
    merges_nxt    = merges_r;
    vidx_nxt      = vidx_r;
    eidx_nxt      = eidx_r;
    cut_nxt       = cut_r;
    rem_nxt       = rem_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    out_valid_nxt = out_valid_r;
    out_cut_nxt   = out_cut_r;
    out_stall_nxt = out_stall_r;

    edge_we    = 1'b0;
    edge_waddr = load_cnt_r[AW-1:0];
    edge_wdata = {VW'(in_tail - 9'd1), VW'(in_head - 9'd1)};
    edge_raddr = rem_r[AW-1:0];
    mark_we    = 1'b0;
    mark_waddr = rem_r[AW-1:0];
    mark_wdata = 1'b1;
    mark_raddr = rem_r[AW-1:0];
    lab_we     = 1'b0;
    lab_waddr  = vidx_r[VW-1:0];
    lab_wdata  = ga_r;
    laba_raddr = edge_rdata[VW-1:0];
    labb_raddr = edge_rdata[2*VW-1:VW];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we && cfg_index == CFG_RNG_SEED) begin
      rng_nxt = (cfg_wdata == '0) ? SEED_W'(1) : cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (edge_ok) begin
            edge_we      = 1'b1;
            load_cnt_nxt = load_cnt_r + CW'(1);
          end
          if (in_tlast) begin
            trial_nxt = '0;
            best_nxt  = CUT_ALL_ONES;
            stall_nxt = 1'b0;
            sweep_nxt = '0;
            state_nxt = S_TINIT;
          end
        end
      end
      S_TINIT: begin
        // Clear marks and set every vertex to its own group, one entry a cycle.
        mark_waddr = sweep_r[AW-1:0];
        mark_wdata = 1'b0;
        lab_waddr  = sweep_r[VW-1:0];
        lab_wdata  = sweep_r[VW-1:0];
        mark_we    = (sweep_r < SW'(load_cnt_r));
        lab_we     = (sweep_r < SW'(nv));
        sweep_nxt  = sweep_r + SW'(1);
        if (!mark_we && !lab_we) begin
          merges_nxt = '0;
          left_nxt   = load_cnt_r;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        eidx_nxt = '0;
        cut_nxt  = '0;
        if (nv < NVW'(3) || ((NVW+1)'(merges_r) + (NVW+1)'(2)) >= (NVW+1)'(nv)) begin
          state_nxt = S_CRD;
        end else if (left_r == '0) begin
          stall_nxt = 1'b1;
          state_nxt = S_CRD;
        end else begin
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        rng_nxt   = xorshift32(rng_r);
        word_nxt  = xorshift32(rng_r);
        rem_nxt   = '0;
        bit_nxt   = 5'd31;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // Restoring remainder, one dividend bit a cycle.
        if (rem_sh >= {1'b0, load_cnt_r}) begin
          rem_nxt = CW'(rem_sh - {1'b0, load_cnt_r});
        end else begin
          rem_nxt = CW'(rem_sh);
        end
        word_nxt = word_r << 1;
        bit_nxt  = bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          state_nxt = S_MREAD;
        end
      end
      S_MREAD: begin
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if (mark_rdata) begin
          state_nxt = S_DRAW;
        end else begin
          mark_we   = 1'b1;
          left_nxt  = left_r - CW'(1);
          state_nxt = S_LCHK;
        end
      end
      S_LCHK: begin
        if (laba_rdata == labb_rdata) begin
          state_nxt = S_CHECK;
        end else begin
          ga_nxt     = laba_rdata;
          gb_nxt     = labb_rdata;
          vidx_nxt   = '0;
          merges_nxt = merges_r + NVW'(1);
          state_nxt  = S_RRD;
        end
      end
      S_RRD: begin
        laba_raddr = vidx_r[VW-1:0];
        if (vidx_r < nv) begin
          state_nxt = S_RWR;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_RWR: begin
        lab_we    = (laba_rdata == gb_r);
        vidx_nxt  = vidx_r + NVW'(1);
        state_nxt = S_RRD;
      end
      S_CRD: begin
        edge_raddr = eidx_r[AW-1:0];
        if (eidx_r < load_cnt_r) begin
          state_nxt = S_CLB;
        end else begin
          state_nxt = S_TEND;
        end
      end
      S_CLB: begin
        state_nxt = S_CCMP;
      end
      S_CCMP: begin
        if (laba_rdata != labb_rdata && cut_r != CUT_ALL_ONES) begin
          cut_nxt = cut_r + CUT_W'(1);
        end
        eidx_nxt  = eidx_r + CW'(1);
        state_nxt = S_CRD;
      end
      S_TEND: begin
        if (cut_r < best_r) begin
          best_nxt = cut_r;
        end
        trial_nxt = trial_r + TC_W'(1);
        sweep_nxt = '0;
        if (((TC_W+1)'(trial_r) + (TC_W+1)'(1)) >= trials) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_TINIT;
        end
      end
      S_FIN: begin
        // Hold until the previous result has been taken.
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_cut_nxt   = best_r;
          out_stall_nxt = stall_r;
          load_cnt_nxt  = '0;
          best_nxt      = CUT_ALL_ONES;
          trial_nxt     = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= VC_W'(2);
      tcount_r    <= TC_W'(1);
      rng_r       <= SEED_W'(1);
      load_cnt_r  <= '0;
      best_r      <= CUT_ALL_ONES;
      trial_r     <= '0;
      stall_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rng_r       <= rng_nxt;
      load_cnt_r  <= load_cnt_nxt;
      best_r      <= best_nxt;
      trial_r     <= trial_nxt;
      stall_r     <= stall_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_VERTEX_COUNT) begin
        vcount_r <= cfg_wdata[VC_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_TRIAL_COUNT) begin
        tcount_r <= cfg_wdata[TC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    sweep_r     <= sweep_nxt;
    left_r      <= left_nxt;
    merges_r    <= merges_nxt;
    vidx_r      <= vidx_nxt;
    eidx_r      <= eidx_nxt;
    cut_r       <= cut_nxt;
    rem_r       <= rem_nxt;
    word_r      <= word_nxt;
    bit_r       <= bit_nxt;
    ga_r        <= ga_nxt;
    gb_r        <= gb_nxt;
    out_cut_r   <= out_cut_nxt;
    out_stall_r <= out_stall_nxt;
  end

  // Load count never runs past the edge store.
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= CW'(MAX_EDGES))
    else $error("edge load count beyond store depth");

  // A finished modulo always picks a stored edge.
  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MREAD |-> rem_r < load_cnt_r)
    else $error("edge pick outside loaded edges");

  // Finishing a run posts a result and empties the store.
  a_fin_post: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !out_valid_r) |=> (out_valid_r && load_cnt_r == '0))
    else $error("result not posted at run end");

endmodule
`default_nettype wire

[tb/tb_random_contraction_min_cut_unit.sv]
// Testbench for the edge-contraction min-cut unit: directed table plus random graphs.
`timescale 1ns / 100ps
`default_nettype none
module tb_random_contraction_min_cut_unit;
  import rcmc_pkg::*;

  localparam int NV_CAP = 256;
  localparam int NE_CAP = 4096;
  localparam int LIMIT_CYCLES = 10000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD = 3000;
  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;  // edge_head[8:0], edge_tail[17:9], zeros
  logic in_tlast = 1'b0;       // last_edge
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;      // min_cut[12:0], stalled[13], zeros
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SEED_W-1:0] cfg_wdata = '0;

  random_contraction_min_cut_unit i_dut (.*);

  always #2 clk = ~clk;

  typedef struct packed {
    logic [CUT_W-1:0] cut;
    logic             stalled;
  } cut_word_t;

  // Directed row: an edge word and, where obvious, its result typed in.
  typedef struct {
    logic [8:0] head;
    logic [8:0] tail;
    logic       last;
    logic       typed;
    int         cut;
    logic       stalled;
  } edge_row_t;

  cut_word_t cut_q[$];
  int errors = 0;
  int cycles = 0;
  int words_sent = 0;
  int results_seen = 0;
  int stalled_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;

  // Shadow of the block's registers and graph storage.
  int unsigned sh_vertices = 2;
  int unsigned sh_trials = 1;
  logic [31:0] sh_rng = 32'd1;
  int unsigned edge_cnt = 0;
  int unsigned edge_a[NE_CAP];
  int unsigned edge_b[NE_CAP];
  logic        collapsed[NE_CAP];
  int unsigned grp[NV_CAP];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when asked.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    cut_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cut = out_tdata[12:0];
      got.stalled = out_tdata[13];
      results_seen++;
      if (got.stalled) stalled_seen++;
      if (cut_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cut=%0d stalled=%0b", $time, got.cut, got.stalled);
      end else begin
        want = cut_q.pop_front();
        if (got.cut !== want.cut) begin
          errors++;
          $display("%0t: min_cut expected %0d actual %0d", $time, want.cut, got.cut);
        end
        if (got.stalled !== want.stalled) begin
          errors++;
          $display("%0t: stalled expected %0b actual %0b", $time, want.stalled, got.stalled);
        end
      end
    end
  end

  function automatic logic [31:0] advance_rng(input logic [31:0] x);
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  // Run all trials on the stored graph and return the least cut.
  task automatic search_min_cut(output cut_word_t res);
    int unsigned nv, trials, best, cut, left, merges, pick, ga, gb;
    logic stall;
    nv = (sh_vertices < NV_CAP) ? sh_vertices : NV_CAP;
    trials = (sh_trials != 0) ? sh_trials : 1;
    best = CUT_ALL_ONES;
    stall = 1'b0;
    for (int t = 0; t < trials; t++) begin
      for (int i = 0; i < edge_cnt; i++) collapsed[i] = 1'b0;
      for (int i = 0; i < nv; i++) grp[i] = i;
      left = edge_cnt;
      merges = 0;
      if (nv >= 3) begin
        while (merges < nv - 2) begin
          if (left == 0) begin
            stall = 1'b1;
            break;
          end
          do begin
            sh_rng = advance_rng(sh_rng);
            pick = sh_rng % edge_cnt;
          end while (collapsed[pick]);
          collapsed[pick] = 1'b1;
          left--;
          ga = grp[edge_a[pick]];
          gb = grp[edge_b[pick]];
          if (ga != gb) begin
            // fold the tail's group into the head's
            for (int i = 0; i < nv; i++)
              if (grp[i] == gb) grp[i] = ga;
            merges++;
          end
        end
      end
      cut = 0;
      for (int i = 0; i < edge_cnt; i++)
        if (grp[edge_a[i]] != grp[edge_b[i]] && cut < CUT_ALL_ONES) cut++;
      if (cut < best) best = cut;
    end
    res.cut = best[CUT_W-1:0];
    res.stalled = stall;
    edge_cnt = 0;
  endtask

  // Offer one edge word; update the shadow once it is taken.
  task automatic send_edge(input logic [8:0] head, input logic [8:0] tail, input logic last,
                           input logic typed = 1'b0, input int cut = 0,
                           input logic stalled = 1'b0);
    int unsigned nv;
    cut_word_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {6'b0, tail, head};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    nv = (sh_vertices < NV_CAP) ? sh_vertices : NV_CAP;
    // drop edges with an endpoint out of range or past a full store
    if (head >= 1 && head <= nv && tail >= 1 && tail <= nv && edge_cnt < NE_CAP) begin
      edge_a[edge_cnt] = head - 1;
      edge_b[edge_cnt] = tail - 1;
      edge_cnt++;
    end
    if (last) begin
      search_min_cut(res);
      if (typed) begin
        res.cut = cut[CUT_W-1:0];
        res.stalled = stalled;
      end
      cut_q.push_back(res);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Wait for every result, then let the sequencer settle.
  task automatic drain;
    while (cut_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_VERTEX_COUNT: sh_vertices = 32'(val[8:0]);
      CFG_TRIAL_COUNT:  sh_trials = 32'(val[15:0]);
      CFG_RNG_SEED:     sh_rng = (val != 0) ? val : 32'd1;
      default: ;
    endcase
  endtask

  task automatic set_graph_regs(input int unsigned nv, input int unsigned trials);
    write_reg(CFG_VERTEX_COUNT, nv);
    write_reg(CFG_TRIAL_COUNT, trials);
    if ($urandom_range(3) == 0) write_reg(CFG_RNG_SEED, $urandom);
  endtask

  // One graph: mostly in-range edges, some noise over the full 9 bits.
  task automatic random_graph(input int unsigned nv, input int unsigned n_edges);
    logic [8:0] h, t;
    for (int i = 0; i < n_edges; i++) begin
      if ($urandom_range(9) == 0) begin
        h = 9'($urandom);
        t = 9'($urandom);
      end else begin
        h = 9'($urandom_range(nv, 1));
        t = 9'($urandom_range(nv, 1));
      end
      send_edge(h, t, i == n_edges - 1);
    end
  endtask

  edge_row_t dir_rows[] = '{
    // two vertices after reset: no contraction, cut counts crossing edges
    '{9'd1, 9'd2, 1'b1, 1'b1, 1, 1'b0},
    '{9'd0, 9'd1, 1'b1, 1'b1, 0, 1'b0},          // zero endpoint dropped, still runs
    '{9'd511, 9'd511, 1'b1, 1'b1, 0, 1'b0},      // endpoints far above range
    '{9'd1, 9'd1, 1'b1, 1'b1, 0, 1'b0},          // self loop never crosses
    '{9'd2, 9'd1, 1'b0, 1'b0, 0, 1'b0},
    '{9'd1, 9'd2, 1'b0, 1'b0, 0, 1'b0},
    '{9'd3, 9'd1, 1'b0, 1'b0, 0, 1'b0},          // beyond vertex_count: dropped
    '{9'd2, 9'd2, 1'b1, 1'b1, 2, 1'b0}
  };

  initial begin
    int unsigned nv;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_edge(dir_rows[i].head, dir_rows[i].tail, dir_rows[i].last,
                dir_rows[i].typed, dir_rows[i].cut, dir_rows[i].stalled);
    drain();

    // Extremes of the registers: zero trials, zero seed, ignored index.
    write_reg(CFG_NO_REG, 32'hFFFF_FFFF);
    write_reg(CFG_VERTEX_COUNT, 3);
    write_reg(CFG_TRIAL_COUNT, 0);
    write_reg(CFG_RNG_SEED, 0);
    send_edge(9'd1, 9'd2, 1'b0);
    send_edge(9'd2, 9'd3, 1'b0);
    send_edge(9'd3, 9'd1, 1'b1);
    send_edge(9'd1, 9'd2, 1'b1);                 // one edge covers the single merge
    send_edge(9'd0, 9'd0, 1'b1);                 // empty graph: cut 0, stalled
    drain();
    write_reg(CFG_RNG_SEED, 32'hFFFF_FFFF);
    write_reg(CFG_VERTEX_COUNT, 32'h1FF);        // clamps to the vertex cap
    write_reg(CFG_TRIAL_COUNT, 2);
    send_edge(9'd256, 9'd1, 1'b0);
    send_edge(9'd257, 9'd1, 1'b0);
    random_graph(256, 20);
    drain();
    write_reg(CFG_VERTEX_COUNT, 1);
    write_reg(CFG_TRIAL_COUNT, 32'hFFFF);
    send_edge(9'd1, 9'd1, 1'b1);
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 79 : (ph == 3) ? 12 : 0;
      recv_stall_pct = (ph == 2) ? 79 : (ph == 3) ? 12 : 0;
      for (int g = 0; g < 36; g++) begin
        if (g % 4 == 0) begin
          drain();
          nv = ($urandom_range(15) == 0) ? $urandom_range(40, 3) : $urandom_range(8, 2);
          set_graph_regs(nv, $urandom_range(4, 1));
        end
        random_graph(nv, $urandom_range(10, 1));
      end
      drain();
    end

    // Hold the result side off so finished graphs back up into the input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_graph_regs(5, 2);
    hold_req = 1'b1;
    for (int g = 0; g < 6; g++) random_graph(5, 4);
    drain();

    $display("Covered %0d edge words and %0d min-cut results (%0d stalled),",
             words_sent, results_seen, stalled_seen);
    $display("over four idle mixes, register extremes and a long output hold.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

[random_contraction_min_cut_unit.f]
rtl/rcmc_pkg.sv
rtl/rcmc_ram.sv
rtl/random_contraction_min_cut_unit.sv
tb/tb_random_contraction_min_cut_unit.sv
